FILE: sv/assert_macros.svh
// Assertion macros used by the top RTL file of the range-rate converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

FILE: sv/crpr_pkg.sv
// Shared constants and the arctangent table of the range-rate converter.
package crpr_pkg;

  localparam int DEF_CORDIC_STG = 20;
  localparam int SQRT_STEPS     = 32;
  localparam int DIV_STEPS      = 33;
  // start accepted -> strobe sampled
  localparam int LATENCY        = 69;

  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [19:0] BEARING_MAX = 20'sd205887;

  // atan(2^-i) in Q2.30, rounded to nearest
  function automatic logic signed [33:0] atan_q30(input int i);
    logic signed [33:0] v;
    case (i)
      0: v = 34'sd843314857;
      1: v = 34'sd497837829;
      2: v = 34'sd263043837;
      3: v = 34'sd133525159;
      4: v = 34'sd67021687;
      5: v = 34'sd33543516;
      6: v = 34'sd16775851;
      7: v = 34'sd8388437;
      8: v = 34'sd4194283;
      9: v = 34'sd2097149;
      default: v = (i < 31) ? (34'sd1 <<< (30 - i)) : 34'sd0;
    endcase
    return v;
  endfunction

endpackage

FILE: sv/crpr_sqrt_cell.sv
// One digit step of the pipelined integer square root.
module crpr_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic        clk,
  input  logic [63:0] n_in,
  input  logic [63:0] res_in,
  output logic [63:0] n_out,
  output logic [63:0] res_out
);

  localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

  logic [63:0] trial;

  assign trial = res_in + BIT;

  // restoring step: keep the bit if the remainder allows it
  always_ff @(posedge clk) begin
    if (n_in >= trial) begin
      n_out   <= n_in - trial;
      res_out <= (res_in >> 1) + BIT;
    end else begin
      n_out   <= n_in;
      res_out <= res_in >> 1;
    end
  end

endmodule

FILE: sv/crpr_cordic_cell.sv
// One vectoring iteration of the bearing CORDIC.
module crpr_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic               clk,
  input  logic signed [63:0] x_in,
  input  logic signed [63:0] y_in,
  input  logic signed [33:0] z_in,
  output logic signed [63:0] x_out,
  output logic signed [63:0] y_out,
  output logic signed [33:0] z_out
);

  localparam logic signed [33:0] ANG = crpr_pkg::atan_q30(STAGE);

  logic signed [63:0] xs, ys;

  assign xs = x_in >>> STAGE;
  assign ys = y_in >>> STAGE;

  // rotate towards the x axis
  always_ff @(posedge clk) begin
    if (!y_in[63]) begin
      x_out <= x_in + ys;
      y_out <= y_in - xs;
      z_out <= z_in + ANG;
    end else begin
      x_out <= x_in - ys;
      y_out <= y_in + xs;
      z_out <= z_in - ANG;
    end
  end

endmodule

FILE: sv/crpr_div_cell.sv
// One quotient bit of the pipelined restoring divider.
module crpr_div_cell #(
  parameter int SHIFT = 0
) (
  input  logic        clk,
  input  logic [63:0] r_in,
  input  logic [32:0] q_in,
  input  logic [31:0] d_in,
  output logic [63:0] r_out,
  output logic [32:0] q_out,
  output logic [31:0] d_out
);

  logic [64:0] dsh;

  assign dsh = 65'(d_in) << SHIFT;

  // compare and subtract the shifted divisor
  always_ff @(posedge clk) begin
    d_out <= d_in;
    if ({1'b0, r_in} >= dsh) begin
      r_out <= r_in - dsh[63:0];
      q_out <= {q_in[31:0], 1'b1};
    end else begin
      r_out <= r_in;
      q_out <= {q_in[31:0], 1'b0};
    end
  end

endmodule

FILE: sv/cartesian_to_polar_range_rate.sv
// Cartesian target state to range, bearing and range rate, fully pipelined.
// One word is taken on every clock in which start is high; busy is always low.
// Each result appears on strobe for one cycle, in input order, after passing
// 1 input stage, 1 multiplier stage, 1 sum stage, 32 square-root cells and
// 33 divider cells, plus the output register. The bearing CORDIC
// (CORDIC_STAGES cells) runs alongside and is delayed to match. Results
// cannot be held off, so the receiver must take each one in its strobe
// cycle. A position at the origin gives zero range, bearing and range rate
// with zero_range set.
`include "assert_macros.svh"
module cartesian_to_polar_range_rate #(
  parameter int CORDIC_STAGES = crpr_pkg::DEF_CORDIC_STG
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] vel_x,
  input  logic signed [31:0] vel_y,
  output logic               strobe,
  output logic        [32:0] range_out,
  output logic signed [18:0] bearing,
  output logic signed [33:0] range_rate,
  output logic               zero_range
);

  localparam int NSQ  = crpr_pkg::SQRT_STEPS;
  localparam int NDV  = crpr_pkg::DIV_STEPS;
  localparam int NVLD = crpr_pkg::LATENCY - 1;
  localparam int BDLY = NVLD - 2 - CORDIC_STAGES;

  // valid line, one bit per register stage
  logic vld [NVLD];

  // input stage
  logic signed [31:0] px, py, vx, vy;
  // product stage
  logic signed [63:0] pxx, pyy, pxv, pyv;
  // sum stage
  logic [63:0] s_sum, mag;
  logic        neg, zro;
  logic signed [64:0] dot;

  assign busy = 1'b0;
  assign dot  = 65'(pxv) + 65'(pyv);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= start;
    end
  end

  for (genvar k = 1; k < NVLD; k++) begin : g_vld
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vld[k-1];
      end
    end
  end

  // input register, multipliers, sums
  always_ff @(posedge clk) begin
    px    <= pos_x;
    py    <= pos_y;
    vx    <= vel_x;
    vy    <= vel_y;
    pxx   <= px * px;
    pyy   <= py * py;
    pxv   <= px * vx;
    pyv   <= py * vy;
    s_sum <= pxx + pyy;
    zro   <= (pxx + pyy) == 64'd0;
    neg   <= dot[64];
    mag   <= dot[64] ? 64'(-dot) : dot[63:0];
  end

  // square-root chain
  logic [63:0] sq_n   [NSQ+1];
  logic [63:0] sq_res [NSQ+1];

  assign sq_n[0]   = s_sum;
  assign sq_res[0] = 64'd0;

  for (genvar i = 0; i < NSQ; i++) begin : g_sq
    crpr_sqrt_cell #(.STEP(i)) u_cell (
      .clk     (clk),
      .n_in    (sq_n[i]),
      .res_in  (sq_res[i]),
      .n_out   (sq_n[i+1]),
      .res_out (sq_res[i+1])
    );
  end

  // dividend and flags follow the root
  logic [63:0] a_mag [NSQ];
  logic        a_neg [NSQ];
  logic        a_zro [NSQ];

  always_ff @(posedge clk) begin
    a_mag[0] <= mag;
    a_neg[0] <= neg;
    a_zro[0] <= zro;
  end

  for (genvar k = 1; k < NSQ; k++) begin : g_a
    always_ff @(posedge clk) begin
      a_mag[k] <= a_mag[k-1];
      a_neg[k] <= a_neg[k-1];
      a_zro[k] <= a_zro[k-1];
    end
  end

  // quotient overflow: mag >= range * 2^33
  logic ovf;
  assign ovf = {2'b00, a_mag[NSQ-1]} >= (66'(sq_res[NSQ][31:0]) << 33);

  // divider chain
  logic [63:0] dv_r [NDV+1];
  logic [32:0] dv_q [NDV+1];
  logic [31:0] dv_d [NDV+1];

  assign dv_r[0] = a_mag[NSQ-1];
  assign dv_q[0] = 33'd0;
  assign dv_d[0] = sq_res[NSQ][31:0];

  for (genvar i = 0; i < NDV; i++) begin : g_dv
    crpr_div_cell #(.SHIFT(NDV - 1 - i)) u_cell (
      .clk   (clk),
      .r_in  (dv_r[i]),
      .q_in  (dv_q[i]),
      .d_in  (dv_d[i]),
      .r_out (dv_r[i+1]),
      .q_out (dv_q[i+1]),
      .d_out (dv_d[i+1])
    );
  end

  logic b_neg [NDV];
  logic b_zro [NDV];
  logic b_ovf [NDV];

  always_ff @(posedge clk) begin
    b_neg[0] <= a_neg[NSQ-1];
    b_zro[0] <= a_zro[NSQ-1];
    b_ovf[0] <= ovf;
  end

  for (genvar k = 1; k < NDV; k++) begin : g_b
    always_ff @(posedge clk) begin
      b_neg[k] <= b_neg[k-1];
      b_zro[k] <= b_zro[k-1];
      b_ovf[k] <= b_ovf[k-1];
    end
  end

  // quadrant fold ahead of the CORDIC
  logic signed [63:0] cx [CORDIC_STAGES+1];
  logic signed [63:0] cy [CORDIC_STAGES+1];
  logic signed [33:0] cz [CORDIC_STAGES+1];
  logic signed [63:0] sx, sy;

  assign sx = {{3{px[31]}}, px, 29'd0};
  assign sy = {{3{py[31]}}, py, 29'd0};

  always_ff @(posedge clk) begin
    if (!sx[63]) begin
      cx[0] <= sx;
      cy[0] <= sy;
      cz[0] <= 34'sd0;
    end else if (!sy[63]) begin
      cx[0] <= sy;
      cy[0] <= -sx;
      cz[0] <= crpr_pkg::HALF_PI_Q30;
    end else begin
      cx[0] <= -sy;
      cy[0] <= sx;
      cz[0] <= -crpr_pkg::HALF_PI_Q30;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cd
    crpr_cordic_cell #(.STAGE(i)) u_cell (
      .clk   (clk),
      .x_in  (cx[i]),
      .y_in  (cy[i]),
      .z_in  (cz[i]),
      .x_out (cx[i+1]),
      .y_out (cy[i+1]),
      .z_out (cz[i+1])
    );
  end

  // round Q2.30 to Q3.16 and clamp
  logic signed [33:0] zr;
  logic signed [19:0] zq, zs;

  assign zr = cz[CORDIC_STAGES] + 34'sd8192;
  assign zq = 20'(zr >>> 14);

  always_comb begin
    if (zq > crpr_pkg::BEARING_MAX) begin
      zs = crpr_pkg::BEARING_MAX;
    end else if (zq < -crpr_pkg::BEARING_MAX) begin
      zs = -crpr_pkg::BEARING_MAX;
    end else begin
      zs = zq;
    end
  end

  // bearing waits for the divider
  logic signed [18:0] bd [BDLY];

  always_ff @(posedge clk) begin
    bd[0] <= zs[18:0];
  end

  for (genvar k = 1; k < BDLY; k++) begin : g_bd
    always_ff @(posedge clk) begin
      bd[k] <= bd[k-1];
    end
  end

  // output register
  logic signed [33:0] qs;
  assign qs = {1'b0, dv_q[NDV]};

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= vld[NVLD-1];
    end
    zero_range <= b_zro[NDV-1];
    if (b_zro[NDV-1]) begin
      range_out  <= 33'd0;
      bearing    <= 19'sd0;
      range_rate <= 34'sd0;
    end else begin
      range_out <= {1'b0, dv_d[NDV]};
      bearing   <= bd[BDLY-1];
      if (b_ovf[NDV-1]) begin
        range_rate <= b_neg[NDV-1] ? {1'b1, 33'd0} : {1'b0, {33{1'b1}}};
      end else begin
        range_rate <= b_neg[NDV-1] ? -qs : qs;
      end
    end
  end

  `ASSERT_PROP(a_latency, clk, rst, strobe |-> $past(start, crpr_pkg::LATENCY), "strobe without start")
  `ASSERT_PROP(a_zero, clk, rst, (strobe && zero_range) |-> (range_out == 33'd0 && range_rate == 34'sd0 && bearing == 19'sd0), "zero range word not cleared")
  `ASSERT_NEVER(a_range, clk, rst, strobe && !zero_range && range_out == 33'd0, "zero root for non-zero position")

endmodule
